// File: rtl/aipr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the +IPD packet receiver.
// No dependencies; aipr_front, aipr_back and the top level import this package.
package aipr_pkg;

  localparam int RING_ROWS_DEF  = 16;
  localparam int ROW_BYTES_DEF  = 20;
  localparam int HEADER_MAX_DEF = 16;

  localparam int OFFSET_W = 5;

  localparam logic [7:0] CONN_ID_RESET = 8'd48;
  localparam logic [7:0] CHAR_COLON    = 8'd58;
  localparam logic [7:0] CHAR_CR       = 8'd13;
  localparam logic [7:0] CHAR_LF       = 8'd10;
  localparam logic [7:0] CHAR_ZERO     = 8'd48;
  localparam logic [7:0] CHAR_NINE     = 8'd57;

  localparam int PREFIX_LEN = 7;
  localparam int ID_POS     = 7;
  localparam int LEN_POS    = 9;
  localparam int CRLF_MIN   = 4;

  localparam logic [1:0] ACT_RX      = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_STORED   = 3'd1;
  localparam logic [2:0] EV_DROPPED  = 3'd2;
  localparam logic [2:0] EV_BAD_HDR  = 3'd3;
  localparam logic [2:0] EV_WRONG_ID = 3'd4;
  localparam logic [2:0] EV_BAD_LEN  = 3'd5;

  typedef enum logic [1:0] {
    K_RX,
    K_READ,
    K_RELEASE,
    K_NOP
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_STORE = 3'b010,
    PH_SKIP  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0]          action;
    logic [7:0]          rx_byte;
    logic [OFFSET_W-1:0] read_offset;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       fifo_empty;
    logic [3:0] packet_count;
    logic [2:0] event_res;
  } out_item_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          rx_byte;
    logic [OFFSET_W-1:0] offset;
    logic                off_ok;
  } cmd_t;

  typedef struct packed {
    logic                rd_ok;
    logic [OFFSET_W-1:0] offset;
    logic                fifo_empty;
    logic [3:0]          packet_count;
    logic [2:0]          event_res;
  } stage_t;

  function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'd13;
      3'd1:    b = 8'd10;
      3'd2:    b = 8'd43;
      3'd3:    b = 8'd73;
      3'd4:    b = 8'd80;
      3'd5:    b = 8'd68;
      3'd6:    b = 8'd44;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/aipr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module aipr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/aipr_front.sv
`timescale 1ns / 1ps
// Front end: accepts input transfers, decodes the action and queues commands.
// Depends on aipr_pkg.
module aipr_front #(
  parameter int ROW_BYTES = aipr_pkg::ROW_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  aipr_pkg::in_item_t in_data,
  output logic              q_valid,
  output aipr_pkg::cmd_t    q_cmd,
  input  logic              q_pop
);

  import aipr_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  cmd_t       cmd_in;
  logic       push;

  always_comb begin
    cmd_in.rx_byte = in_data.rx_byte;
    cmd_in.offset  = in_data.read_offset;
    cmd_in.off_ok  = int'(in_data.read_offset) < ROW_BYTES;
    case (in_data.action)
      ACT_RX:      cmd_in.kind = K_RX;
      ACT_READ:    cmd_in.kind = K_READ;
      ACT_RELEASE: cmd_in.kind = K_RELEASE;
      default:     cmd_in.kind = K_NOP;
    endcase
  end

  assign in_stall = count_r == 2'd2;
  assign push     = in_valid && !in_stall;
  assign q_valid  = count_r != 2'd0;
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// File: rtl/aipr_back.sv
`timescale 1ns / 1ps
// Back end: header parser, packet ring and result stages.
// Depends on aipr_pkg and aipr_ram.
module aipr_back #(
  parameter int RING_ROWS  = aipr_pkg::RING_ROWS_DEF,
  parameter int ROW_BYTES  = aipr_pkg::ROW_BYTES_DEF,
  parameter int HEADER_MAX = aipr_pkg::HEADER_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  aipr_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  output logic               out_valid,
  input  logic               out_stall,
  output aipr_pkg::out_item_t out_data
);

  import aipr_pkg::*;

  localparam int ROW_W  = (RING_ROWS > 1) ? $clog2(RING_ROWS) : 1;
  localparam int CNT_W  = ROW_W + 1;
  localparam int LEN_W  = $clog2(ROW_BYTES);
  localparam int ACC_W  = LEN_W + 4;
  localparam int FILL_W = $clog2(HEADER_MAX);
  localparam int DEPTH  = RING_ROWS * ROW_BYTES;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(RING_ROWS - 1);
  localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(ROW_BYTES);
  localparam logic [ACC_W-1:0]  LEN_LIMIT = ACC_W'(ROW_BYTES - 1);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(HEADER_MAX - 1);

  logic [7:0]        conn_id_r;
  phase_t            phase_r, phase_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              prev_cr_r, prev_cr_nxt;
  logic              prefix_ok_r, prefix_ok_nxt;
  logic [7:0]        id_r, id_nxt;
  logic              bad_r, bad_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [ROW_W-1:0]  wrow_r, wrow_nxt;
  logic [ROW_W-1:0]  rrow_r, rrow_nxt;

  logic              s1_valid_r;
  stage_t            s1_r, s1_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r, out_item;

  logic              fire, s1_go;
  logic              nonempty, full;
  logic [ROW_W-1:0]  wrow_inc, rrow_inc;
  logic [ADDR_W-1:0] wr_base, rd_base;
  logic [CNT_W-1:0]  cnt;
  logic [7:0]        b;
  logic              term;
  logic [7:0]        id_val;
  logic [7:0]        digit;
  logic              is_digit;
  logic [ACC_W-1:0]  acc;
  logic [2:0]        ev;

  logic              dwr_en, lwr_en, rd_en;
  logic [ADDR_W-1:0] dwr_addr, drd_addr;
  logic [7:0]        dwr_data, drd_data;
  logic [LEN_W-1:0]  lrd_data;

  assign s1_go = s1_valid_r && (!out_valid_r || !out_stall);
  assign fire  = q_valid && (!s1_valid_r || s1_go);
  assign q_pop = fire;

  assign nonempty = wrow_r != rrow_r;
  assign wrow_inc = (wrow_r == ROW_LAST) ? '0 : wrow_r + 1'b1;
  assign rrow_inc = (rrow_r == ROW_LAST) ? '0 : rrow_r + 1'b1;
  assign full     = wrow_inc == rrow_r;
  assign wr_base  = ADDR_W'(wrow_r) * ROW_SPAN;
  assign rd_base  = ADDR_W'(rrow_r) * ROW_SPAN;

  assign b        = q_cmd.rx_byte;
  assign term     = (b == CHAR_COLON) || (fill_r == FILL_LAST) ||
                    (fill_r > FILL_W'(CRLF_MIN) && prev_cr_r && b == CHAR_LF);
  assign id_val   = (fill_r == FILL_W'(ID_POS)) ? b : id_r;
  assign digit    = b - CHAR_ZERO;
  assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  assign acc      = (ACC_W'(len_r) << 3) + (ACC_W'(len_r) << 1) + ACC_W'(digit[3:0]);

  always_comb begin
    phase_nxt     = phase_r;
    fill_nxt      = fill_r;
    prev_cr_nxt   = prev_cr_r;
    prefix_ok_nxt = prefix_ok_r;
    id_nxt        = id_r;
    bad_nxt       = bad_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    wrow_nxt      = wrow_r;
    rrow_nxt      = rrow_r;
    ev            = EV_NONE;
    dwr_en        = 1'b0;
    lwr_en        = 1'b0;
    dwr_addr      = wr_base + ADDR_W'(pos_r);
    dwr_data      = b;
    rd_en         = 1'b0;
    drd_addr      = rd_base + (q_cmd.off_ok ? ADDR_W'(q_cmd.offset) : '0);

    if (fire) begin
      case (q_cmd.kind)
        K_RX: begin
          case (phase_r)
            PH_STORE: begin
              dwr_en  = 1'b1;
              pos_nxt = pos_r + 1'b1;
              rem_nxt = rem_r - 1'b1;
              if (rem_r == LEN_W'(1)) begin
                wrow_nxt  = wrow_inc;
                phase_nxt = PH_HUNT;
                ev        = EV_STORED;
              end
            end
            PH_SKIP: begin
              rem_nxt = rem_r - 1'b1;
              if (rem_r == LEN_W'(1)) begin
                phase_nxt = PH_HUNT;
              end
            end
            default: begin
              if (term) begin
                fill_nxt = '0;
                bad_nxt  = 1'b0;
                len_nxt  = '0;
                if (b != CHAR_COLON || fill_r < FILL_W'(ID_POS) || !prefix_ok_r) begin
                  ev = EV_BAD_HDR;
                end else if (id_val != conn_id_r) begin
                  ev = EV_WRONG_ID;
                end else if (bad_r) begin
                  ev = EV_BAD_LEN;
                end else if (full) begin
                  ev        = EV_DROPPED;
                  rem_nxt   = len_r;
                  phase_nxt = (len_r != '0) ? PH_SKIP : PH_HUNT;
                end else begin
                  dwr_en   = 1'b1;
                  lwr_en   = 1'b1;
                  dwr_addr = wr_base;
                  dwr_data = 8'(len_r);
                  if (len_r == '0) begin
                    wrow_nxt = wrow_inc;
                    ev       = EV_STORED;
                  end else begin
                    rem_nxt   = len_r;
                    pos_nxt   = LEN_W'(1);
                    phase_nxt = PH_STORE;
                  end
                end
              end else begin
                fill_nxt    = fill_r + 1'b1;
                prev_cr_nxt = b == CHAR_CR;
                if (fill_r == '0) begin
                  prefix_ok_nxt = b == prefix_byte(3'd0);
                end else if (fill_r < FILL_W'(PREFIX_LEN)) begin
                  prefix_ok_nxt = prefix_ok_r && (b == prefix_byte(fill_r[2:0]));
                end
                if (fill_r == FILL_W'(ID_POS)) begin
                  id_nxt = b;
                end
                if (fill_r >= FILL_W'(LEN_POS) && !bad_r) begin
                  if (!is_digit || acc > LEN_LIMIT) begin
                    bad_nxt = 1'b1;
                  end else begin
                    len_nxt = LEN_W'(acc);
                  end
                end
              end
            end
          endcase
        end
        K_READ: begin
          rd_en = 1'b1;
        end
        K_RELEASE: begin
          if (nonempty) begin
            rrow_nxt = rrow_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (wrow_nxt >= rrow_nxt) begin
      cnt = CNT_W'(wrow_nxt) - CNT_W'(rrow_nxt);
    end else begin
      cnt = CNT_W'(wrow_nxt) + CNT_W'(RING_ROWS) - CNT_W'(rrow_nxt);
    end
    s1_nxt.rd_ok        = (q_cmd.kind == K_READ) && nonempty && q_cmd.off_ok;
    s1_nxt.offset       = q_cmd.offset;
    s1_nxt.fifo_empty   = wrow_nxt == rrow_nxt;
    s1_nxt.packet_count = 4'(cnt);
    s1_nxt.event_res    = ev;
  end

  always_comb begin
    out_item.fifo_empty   = s1_r.fifo_empty;
    out_item.packet_count = s1_r.packet_count;
    out_item.event_res    = s1_r.event_res;
    if (s1_r.rd_ok && (9'(s1_r.offset) <= 9'(lrd_data))) begin
      out_item.read_data = drd_data;
    end else begin
      out_item.read_data = 8'd0;
    end
  end

  aipr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (dwr_en),
    .wr_addr (dwr_addr),
    .wr_data (dwr_data),
    .rd_en   (rd_en),
    .rd_addr (drd_addr),
    .rd_data (drd_data)
  );

  aipr_ram #(
    .WIDTH (LEN_W),
    .DEPTH (RING_ROWS)
  ) u_len_ram (
    .clk     (clk),
    .wr_en   (lwr_en),
    .wr_addr (wrow_r),
    .wr_data (len_r),
    .rd_en   (rd_en),
    .rd_addr (rrow_r),
    .rd_data (lrd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_id_r   <= CONN_ID_RESET;
      phase_r     <= PH_HUNT;
      fill_r      <= '0;
      prev_cr_r   <= 1'b0;
      prefix_ok_r <= 1'b0;
      bad_r       <= 1'b0;
      len_r       <= '0;
      rem_r       <= '0;
      pos_r       <= '0;
      wrow_r      <= '0;
      rrow_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        conn_id_r <= cfg_wr_data;
      end
      phase_r     <= phase_nxt;
      fill_r      <= fill_nxt;
      prev_cr_r   <= prev_cr_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      bad_r       <= bad_nxt;
      len_r       <= len_nxt;
      rem_r       <= rem_nxt;
      pos_r       <= pos_nxt;
      wrow_r      <= wrow_nxt;
      rrow_r      <= rrow_nxt;
      if (fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    if (fire) begin
      s1_r <= s1_nxt;
    end
    if (s1_go) begin
      out_data_r <= out_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/at_ipd_packet_receiver_unit.sv
`timescale 1ns / 1ps
// Receiver for +IPD data frames from an AT-command modem: top level.
// Depends on aipr_pkg, aipr_front, aipr_back and aipr_ram.
//
// Each input transfer is a received serial byte, a read of one byte of the
// oldest stored packet, a release of that packet or a no-op for the unused
// action code, and each produces exactly one result transfer. A header of up
// to HEADER_MAX bytes is parsed on the fly; a valid header with the configured
// connection identifier stores its length and payload in a ring of RING_ROWS
// rows of ROW_BYTES bytes. The block sustains one transfer per clock cycle
// while out_stall is low; a result passes from the two-entry command queue
// through the execute step of the back end, whose registered row read lands
// in the output register. The ring memory needs no clearing pass after
// reset. The connection identifier resets to the character '0' and is written
// through cfg_wr_en and cfg_wr_data.
module at_ipd_packet_receiver_unit #(
  parameter int RING_ROWS  = aipr_pkg::RING_ROWS_DEF,
  parameter int ROW_BYTES  = aipr_pkg::ROW_BYTES_DEF,
  parameter int HEADER_MAX = aipr_pkg::HEADER_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aipr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aipr_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);

  import aipr_pkg::*;

  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  aipr_front #(
    .ROW_BYTES (ROW_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  aipr_back #(
    .RING_ROWS  (RING_ROWS),
    .ROW_BYTES  (ROW_BYTES),
    .HEADER_MAX (HEADER_MAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
